// File: rtl/agtf_pkg.sv
// shared types and constants of the affinity gated task fifo
package agtf_pkg;

   localparam int GRP_W     = 3;
   localparam int GRP_SLOTS = 8;
   localparam int AFF_W     = 5;
   localparam int CNT_W     = 16;
   localparam int PEND_W    = 8;
   localparam int FILL_OUT_W = 8;

   localparam logic [AFF_W-1:0] AFF_ANY = 5'h1F;
   localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      ACT_PUSH         = 2'd0,
      ACT_FETCH_STRICT = 2'd1,
      ACT_FETCH_ANY    = 2'd2,
      ACT_COMPLETE     = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_MISMATCH  = 3'd2,
      ST_FULL      = 3'd3,
      ST_UNDERFLOW = 3'd4
   } status_type;

   // counter update request from the queue control
   typedef struct packed {
      logic             inc;
      logic             dec;
      logic [GRP_W-1:0] grp;
   } cnt_req_type;

   // counter status back to the queue control
   typedef struct packed {
      logic              underflow;
      logic [PEND_W-1:0] pending;
   } cnt_stat_type;

endpackage

// File: rtl/agtf_entry_ram.sv
// entry memory with registered read and write-first bypass
module agtf_entry_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // same-cycle write to the read slot is forwarded
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/agtf_group_counters.sv
// per-group outstanding task counters and pending flags
module agtf_group_counters #(
   parameter int GROUP_COUNT = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  agtf_pkg::cnt_req_type  cnt_req,
   output agtf_pkg::cnt_stat_type cnt_stat
);
   import agtf_pkg::*;

   localparam int LIVE = (GROUP_COUNT < GRP_SLOTS) ? GROUP_COUNT : GRP_SLOTS;

   logic [CNT_W-1:0]  cnt_ff [LIVE];
   logic [CNT_W-1:0]  cnt_in [LIVE];
   logic [PEND_W-1:0] pend_ff;
   logic [PEND_W-1:0] pend_in;
   logic [LIVE-1:0]   under_hit;

   // group 0 never counts
   always_comb begin
      pend_in   = '0;
      under_hit = '0;
      for (int g = 0; g < LIVE; g++) begin
         cnt_in[g] = cnt_ff[g];
         if ((g != 0) && (cnt_req.grp == GRP_W'(g))) begin
            if (cnt_req.inc && (cnt_ff[g] != CNT_MAX)) begin
               cnt_in[g] = cnt_ff[g] + 1'b1;
            end
            if (cnt_req.dec) begin
               if (cnt_ff[g] == '0) begin
                  under_hit[g] = 1'b1;
               end else begin
                  cnt_in[g] = cnt_ff[g] - 1'b1;
               end
            end
         end
         if (g != 0) begin
            pend_in[g] = (cnt_in[g] != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < LIVE; g++) begin
            cnt_ff[g] <= '0;
         end
         pend_ff <= '0;
      end else begin
         for (int g = 0; g < LIVE; g++) begin
            cnt_ff[g] <= cnt_in[g];
         end
         pend_ff <= pend_in;
      end
   end

   assign cnt_stat.underflow = |under_hit;
   assign cnt_stat.pending   = pend_ff;

endmodule

// File: rtl/affinity_gated_task_fifo_top.sv
// affinity gated task fifo: command register, queue control and result register
//
// usage
//   input channel: a transaction is taken at a rising edge with start high and
//   busy low; busy stays low, so one transaction can be issued every cycle.
//   req_action selects push, strict fetch, relaxed fetch or complete.
//   result channel: rsp_valid is high for exactly one cycle per transaction,
//   carrying status, the fetched entry, group pending flags and queue fill.
// pipeline and throughput
//   a taken transaction is registered in the input register, processed by the
//   queue control and its result is registered in the result register;
//   throughput is one transaction per cycle, set by the single
//   head read port of the entry memory, which is prefetched at the next head
// reset
//   synchronous reset empties the queue and clears all group counters; the
//   entry memory is not cleared, only written slots are ever handed out
// stalls
//   the receiver cannot hold off results; every result is shown once
module affinity_gated_task_fifo_top #(
   parameter int QUEUE_DEPTH = 128,
   parameter int GROUP_COUNT = 8,
   parameter int TAG_BITS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   // command channel
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_action,
   input  logic [TAG_BITS-1:0] req_task_tag,
   input  logic [2:0]          req_task_group,
   input  logic signed [4:0]   req_task_affinity,
   input  logic signed [4:0]   req_want_affinity,
   // result channel
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic [TAG_BITS-1:0] rsp_out_tag,
   output logic [2:0]          rsp_out_group,
   output logic signed [4:0]   rsp_out_affinity,
   output logic [7:0]          rsp_group_pending,
   output logic [7:0]          rsp_queue_fill
);
   import agtf_pkg::*;

   localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = TAG_BITS + GRP_W + AFF_W;

   // input register
   logic                req_valid_ff;
   action_type          req_action_ff;
   logic [TAG_BITS-1:0] req_tag_ff;
   logic [GRP_W-1:0]    req_group_ff;
   logic [AFF_W-1:0]    req_taff_ff;
   logic [AFF_W-1:0]    req_waff_ff;

   // queue state
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   // result register
   logic                rsp_valid_ff;
   status_type          status_ff, status_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [GRP_W-1:0]    grp_ff, grp_in;
   logic [AFF_W-1:0]    aff_ff, aff_in;

   // head entry and control terms
   logic [ENTRY_W-1:0]  head_entry;
   logic [TAG_BITS-1:0] head_tag;
   logic [GRP_W-1:0]    head_grp;
   logic [AFF_W-1:0]    head_aff;
   logic                is_push, is_fetch, is_complete;
   logic                q_full, q_empty, aff_match;
   logic                push_ok, pop_ok;
   cnt_req_type         cnt_req;
   cnt_stat_type        cnt_stat;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_action_ff <= action_type'(req_action);
         req_tag_ff    <= req_task_tag;
         req_group_ff  <= req_task_group;
         req_taff_ff   <= req_task_affinity;
         req_waff_ff   <= req_want_affinity;
      end
   end

   assign {head_tag, head_grp, head_aff} = head_entry;

   assign is_push     = req_valid_ff && (req_action_ff == ACT_PUSH);
   assign is_fetch    = req_valid_ff && ((req_action_ff == ACT_FETCH_STRICT) ||
                                         (req_action_ff == ACT_FETCH_ANY));
   assign is_complete = req_valid_ff && (req_action_ff == ACT_COMPLETE);
   assign q_full      = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign q_empty     = (fill_ff == '0);

   // relaxed fetch also takes an any-worker head
   assign aff_match = (head_aff == req_waff_ff) ||
                      ((req_action_ff == ACT_FETCH_ANY) && (head_aff == AFF_ANY));

   assign push_ok = is_push && !q_full;
   assign pop_ok  = is_fetch && !q_empty && aff_match;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (pop_ok) begin
         head_in = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         fill_in = fill_ff - 1'b1;
      end
      if (push_ok) begin
         tail_in = (tail_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         fill_in = fill_ff + 1'b1;
      end
   end

   // status and fetched fields
   always_comb begin
      status_in = ST_OK;
      tag_in    = '0;
      grp_in    = '0;
      aff_in    = '0;
      if (is_push && q_full) begin
         status_in = ST_FULL;
      end else if (is_fetch && q_empty) begin
         status_in = ST_EMPTY;
      end else if (is_fetch && !aff_match) begin
         status_in = ST_MISMATCH;
      end else if (pop_ok) begin
         tag_in = head_tag;
         grp_in = head_grp;
         aff_in = head_aff;
      end else if (is_complete && cnt_stat.underflow) begin
         status_in = ST_UNDERFLOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      tag_ff    <= tag_in;
      grp_ff    <= grp_in;
      aff_ff    <= aff_in;
   end

   // memory reads the next head so its data is ready for the next transaction
   agtf_entry_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (push_ok),
      .wr_addr (tail_ff),
      .wr_data ({req_tag_ff, req_group_ff, req_taff_ff}),
      .rd_addr (head_in),
      .rd_data (head_entry)
   );

   assign cnt_req.inc = push_ok;
   assign cnt_req.dec = is_complete;
   assign cnt_req.grp = req_group_ff;

   agtf_group_counters #(
      .GROUP_COUNT (GROUP_COUNT)
   ) u_group_counters (
      .clock    (clock),
      .reset    (reset),
      .cnt_req  (cnt_req),
      .cnt_stat (cnt_stat)
   );

   // pending flags and fill are registered on the same edge as the result
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_out_tag       = tag_ff;
   assign rsp_out_group     = grp_ff;
   assign rsp_out_affinity  = aff_ff;
   assign rsp_group_pending = cnt_stat.pending;
   assign rsp_queue_fill    = FILL_OUT_W'(fill_ff);

endmodule

// File: rtl/agtf_checker.sv
// port level checker for the affinity gated task fifo and its bind
module agtf_checker #(
   parameter int TAG_BITS = 16
) (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [2:0]          rsp_status,
   input logic [TAG_BITS-1:0] rsp_out_tag,
   input logic [2:0]          rsp_out_group,
   input logic [4:0]          rsp_out_affinity,
   input logic [7:0]          rsp_group_pending
);
   import agtf_pkg::*;

   // every accepted transaction gets its result after the input and result registers
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted transaction produced no result");

   // no result without an accepted transaction
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without transaction");

   // only a successful fetch carries entry fields
   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |->
         ((rsp_out_tag == '0) && (rsp_out_group == '0) && (rsp_out_affinity == '0)))
      else $error("entry fields set on failed transaction");

   // the ungrouped group is never pending
   a_group0_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_group_pending[0])
      else $error("group 0 reported pending");

endmodule

bind affinity_gated_task_fifo_top agtf_checker #(
   .TAG_BITS (TAG_BITS)
) u_agtf_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_out_tag       (rsp_out_tag),
   .rsp_out_group     (rsp_out_group),
   .rsp_out_affinity  (rsp_out_affinity),
   .rsp_group_pending (rsp_group_pending)
);

// File: sim/agtf_result_checker.sv
// result checker for the affinity gated task fifo: predicts every result and compares it
module agtf_result_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [1:0]        req_action,
   input  logic [15:0]       req_task_tag,
   input  logic [2:0]        req_task_group,
   input  logic signed [4:0] req_task_affinity,
   input  logic signed [4:0] req_want_affinity,
   input  logic              rsp_valid,
   input  logic [2:0]        rsp_status,
   input  logic [15:0]       rsp_out_tag,
   input  logic [2:0]        rsp_out_group,
   input  logic signed [4:0] rsp_out_affinity,
   input  logic [7:0]        rsp_group_pending,
   input  logic [7:0]        rsp_queue_fill,
   output int                results_due,
   output int                fail_count
);
   import agtf_pkg::*;

   localparam int SLOTS = 128;

   typedef struct {
      status_type  status;
      logic [15:0] tag;
      logic [2:0]  grp;
      logic [4:0]  aff;
      logic [7:0]  pend;
      logic [7:0]  fill;
   } task_result_type;

   logic [15:0]      slot_tag [SLOTS];
   logic [2:0]       slot_grp [SLOTS];
   logic [4:0]       slot_aff [SLOTS];
   logic [6:0]       head_ptr;
   logic [6:0]       tail_ptr;
   int               entries;
   logic [CNT_W-1:0] group_load [GRP_SLOTS];

   task_result_type  due_q [$];
   int               errors;

   // applies one transaction to the queue image and returns its result
   task automatic run_task_queue(input action_type act, input logic [15:0] tag,
                                 input logic [2:0] grp, input logic [4:0] taff,
                                 input logic [4:0] waff, output task_result_type res);
      res = '{ST_OK, 16'd0, 3'd0, 5'd0, 8'd0, 8'd0};
      case (act)
         ACT_PUSH: begin
            if (entries >= SLOTS) begin
               res.status = ST_FULL;
            end else begin
               if (grp != 0 && group_load[grp] != CNT_MAX) group_load[grp]++;
               slot_tag[tail_ptr] = tag;
               slot_grp[tail_ptr] = grp;
               slot_aff[tail_ptr] = taff;
               tail_ptr++;
               entries++;
            end
         end
         ACT_FETCH_STRICT, ACT_FETCH_ANY: begin
            if (entries == 0) begin
               res.status = ST_EMPTY;
            end else if (slot_aff[head_ptr] == waff ||
                         (act == ACT_FETCH_ANY && slot_aff[head_ptr] == AFF_ANY)) begin
               res.tag = slot_tag[head_ptr];
               res.grp = slot_grp[head_ptr];
               res.aff = slot_aff[head_ptr];
               head_ptr++;
               entries--;
            end else begin
               res.status = ST_MISMATCH;
            end
         end
         default: begin
            // group 0 is never counted
            if (grp != 0) begin
               if (group_load[grp] == 0) res.status = ST_UNDERFLOW;
               else group_load[grp]--;
            end
         end
      endcase
      for (int g = 1; g < GRP_SLOTS; g++) res.pend[g] = (group_load[g] != 0);
      res.fill = entries[7:0];
   endtask

   always @(posedge clock) begin
      task_result_type seen;
      task_result_type want;
      if (reset) begin
         head_ptr = '0;
         tail_ptr = '0;
         entries  = 0;
         for (int g = 0; g < GRP_SLOTS; g++) group_load[g] = '0;
         due_q.delete();
         errors = 0;
      end else begin
         if (rsp_valid) begin
            seen = '{status_type'(rsp_status), rsp_out_tag, rsp_out_group,
                     rsp_out_affinity, rsp_group_pending, rsp_queue_fill};
            if (due_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result: status %0d tag %h fill %0d",
                           seen.status, seen.tag, seen.fill);
            end else begin
               want = due_q.pop_front();
               if (seen.status !== want.status || seen.tag !== want.tag ||
                   seen.grp !== want.grp || seen.aff !== want.aff ||
                   seen.pend !== want.pend || seen.fill !== want.fill) begin
                  errors++;
                  if (errors <= 10) begin
                     $display({"mismatch expected: status %0d tag %h grp %0d",
                               " aff %0d pend %b fill %0d"},
                              want.status, want.tag, want.grp, $signed(want.aff),
                              want.pend, want.fill);
                     $display({"         actual:   status %0d tag %h grp %0d",
                               " aff %0d pend %b fill %0d"},
                              seen.status, seen.tag, seen.grp, $signed(seen.aff),
                              seen.pend, seen.fill);
                  end
               end
            end
         end
         if (start && !busy) begin
            run_task_queue(action_type'(req_action), req_task_tag, req_task_group,
                           req_task_affinity, req_want_affinity, want);
            due_q.push_back(want);
         end
      end
      results_due <= due_q.size();
      fail_count  <= errors;
   end

endmodule

// File: sim/tb_top.sv
// testbench top for the affinity gated task fifo: stimulus, watchdog and verdict
module tb_top;
   import agtf_pkg::*;

   localparam int SLOTS       = 128;
   localparam int IDLE_LIMIT  = 1000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_action = ACT_PUSH;
   logic [15:0]       req_task_tag = '0;
   logic [2:0]        req_task_group = '0;
   logic signed [4:0] req_task_affinity = '0;
   logic signed [4:0] req_want_affinity = '0;
   logic              rsp_valid;
   logic [2:0]        rsp_status;
   logic [15:0]       rsp_out_tag;
   logic [2:0]        rsp_out_group;
   logic signed [4:0] rsp_out_affinity;
   logic [7:0]        rsp_group_pending;
   logic [7:0]        rsp_queue_fill;

   int results_due;
   int fail_count;
   int idle_cycles = 0;

   // stimulus-side view of the queue, only used to steer fetches and completes
   logic [4:0] head_affs [$];
   int         open_tasks [GRP_SLOTS];
   int         burst_left = 0;
   bit         gaps_on = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   affinity_gated_task_fifo_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_task_tag      (req_task_tag),
      .req_task_group    (req_task_group),
      .req_task_affinity (req_task_affinity),
      .req_want_affinity (req_want_affinity),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_out_tag       (rsp_out_tag),
      .rsp_out_group     (rsp_out_group),
      .rsp_out_affinity  (rsp_out_affinity),
      .rsp_group_pending (rsp_group_pending),
      .rsp_queue_fill    (rsp_queue_fill)
   );

   agtf_result_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_task_tag      (req_task_tag),
      .req_task_group    (req_task_group),
      .req_task_affinity (req_task_affinity),
      .req_want_affinity (req_want_affinity),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_out_tag       (rsp_out_tag),
      .rsp_out_group     (rsp_out_group),
      .rsp_out_affinity  (rsp_out_affinity),
      .rsp_group_pending (rsp_group_pending),
      .rsp_queue_fill    (rsp_queue_fill),
      .results_due       (results_due),
      .fail_count        (fail_count)
   );

   // watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // drop start and let the given number of cycles go by
   task automatic pause(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // hold off until every predicted result has come back
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   // mostly in-range affinities, now and then any 5-bit pattern
   function automatic logic [4:0] pick_aff();
      if ($urandom_range(0, 15) == 0) return 5'($urandom);
      return 5'($urandom_range(0, 16) - 1);
   endfunction

   // issue one transaction, inserting a random gap between bursts
   task automatic send_op(input action_type act, input logic [15:0] tag,
                          input logic [2:0] grp, input logic [4:0] taff,
                          input logic [4:0] waff);
      if (gaps_on) begin
         if (burst_left == 0) begin
            pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      req_action        <= act;
      req_task_tag      <= tag;
      req_task_group    <= grp;
      req_task_affinity <= taff;
      req_want_affinity <= waff;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
      // keep the stimulus view in step with the transaction just taken
      case (act)
         ACT_PUSH: begin
            if (head_affs.size() < SLOTS) begin
               head_affs.push_back(taff);
               if (grp != 0 && open_tasks[grp] < 65535) open_tasks[grp]++;
            end
         end
         ACT_FETCH_STRICT, ACT_FETCH_ANY: begin
            if (head_affs.size() != 0 && (head_affs[0] == waff ||
                (act == ACT_FETCH_ANY && head_affs[0] == AFF_ANY)))
               void'(head_affs.pop_front());
         end
         default: begin
            if (grp != 0 && open_tasks[grp] > 0) open_tasks[grp]--;
         end
      endcase
   endtask

   // well-formed fetch of the current head
   task automatic fetch_head();
      logic [4:0] h;
      h = head_affs[0];
      if (h == AFF_ANY && $urandom_range(0, 1) == 1)
         send_op(ACT_FETCH_ANY, 16'($urandom), 3'($urandom), pick_aff(), pick_aff());
      else
         send_op($urandom_range(0, 1) ? ACT_FETCH_STRICT : ACT_FETCH_ANY,
                 16'($urandom), 3'($urandom), pick_aff(), h);
   endtask

   // one random transaction; push_pct sets how fast the queue tends to fill
   task automatic random_op(input int push_pct);
      int         roll;
      logic [2:0] live [$];
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
         send_op(ACT_PUSH, 16'($urandom), 3'($urandom), pick_aff(), pick_aff());
      end else if (roll < push_pct + (100 - push_pct) * 6 / 10) begin
         if (head_affs.size() != 0 && $urandom_range(0, 4) != 0)
            fetch_head();
         else
            send_op($urandom_range(0, 1) ? ACT_FETCH_STRICT : ACT_FETCH_ANY,
                    16'($urandom), 3'($urandom), pick_aff(), pick_aff());
      end else begin
         for (int g = 1; g < GRP_SLOTS; g++) if (open_tasks[g] > 0) live.push_back(3'(g));
         if (live.size() != 0 && $urandom_range(0, 4) != 0)
            send_op(ACT_COMPLETE, 16'($urandom), live[$urandom_range(0, live.size() - 1)],
                    pick_aff(), pick_aff());
         else
            send_op(ACT_COMPLETE, 16'($urandom), 3'($urandom), pick_aff(), pick_aff());
      end
   endtask

   initial begin
      int push_pct;
      for (int g = 0; g < GRP_SLOTS; g++) open_tasks[g] = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty queue, complete of ungrouped and of an idle group
      send_op(ACT_FETCH_STRICT, 16'h1111, 3'd0, 5'd0, 5'd0);
      send_op(ACT_FETCH_ANY,    16'h2222, 3'd0, 5'd0, AFF_ANY);
      send_op(ACT_COMPLETE,     16'h0000, 3'd0, 5'd0, 5'd0);
      send_op(ACT_COMPLETE,     16'hFFFF, 3'd3, 5'd0, 5'd0);
      // pushes at the field extremes, including an out-of-range affinity
      send_op(ACT_PUSH, 16'h0000, 3'd0, AFF_ANY, 5'd0);
      send_op(ACT_PUSH, 16'hFFFF, 3'd7, 5'd15,   AFF_ANY);
      send_op(ACT_PUSH, 16'h1234, 3'd1, 5'd0,    5'd15);
      send_op(ACT_PUSH, 16'hA5A5, 3'd3, 5'h10,   5'd0);
      send_op(ACT_PUSH, 16'h5A5A, 3'd2, AFF_ANY, 5'd0);
      // any-affinity head: strict needs an exact -1, relaxed takes anything
      send_op(ACT_FETCH_STRICT, 16'h0, 3'd0, 5'd0, 5'd5);
      send_op(ACT_FETCH_STRICT, 16'h0, 3'd0, 5'd0, AFF_ANY);
      // head with affinity 15
      send_op(ACT_FETCH_ANY,    16'h0, 3'd0, 5'd0, 5'd3);
      send_op(ACT_FETCH_STRICT, 16'h0, 3'd0, 5'd0, 5'd15);
      // counter down to zero and then below it
      send_op(ACT_COMPLETE, 16'h0, 3'd7, 5'd0, 5'd0);
      send_op(ACT_COMPLETE, 16'h0, 3'd7, 5'd0, 5'd0);
      send_op(ACT_FETCH_ANY,    16'h0, 3'd0, 5'd0, 5'd0);
      send_op(ACT_FETCH_STRICT, 16'h0, 3'd0, 5'd0, 5'h10);
      send_op(ACT_FETCH_ANY,    16'h0, 3'd0, 5'd0, 5'd11);
      send_op(ACT_FETCH_ANY,    16'h0, 3'd0, 5'd0, 5'd11);
      send_op(ACT_COMPLETE, 16'h0, 3'd1, 5'd0, 5'd0);
      send_op(ACT_COMPLETE, 16'h0, 3'd3, 5'd0, 5'd0);
      send_op(ACT_COMPLETE, 16'h0, 3'd2, 5'd0, 5'd0);

      // fill to the brim, push into a full queue, then drain back-to-back
      for (int i = 0; i < SLOTS + 2; i++)
         send_op(ACT_PUSH, 16'($urandom), 3'($urandom), pick_aff(), pick_aff());
      gaps_on = 1'b0;
      while (head_affs.size() != 0) fetch_head();
      gaps_on = 1'b1;
      settle();

      // random traffic with a changing push mix
      push_pct = 40;
      for (int i = 0; i < 270; i++) begin
         if (i % 54 == 0) begin
            case ($urandom_range(0, 3))
               0: push_pct = 15;
               1: push_pct = 35;
               2: push_pct = 50;
               default: push_pct = 85;
            endcase
         end
         if (i == 135) settle();
         random_op(push_pct);
      end

      settle();
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
